// ===== sv/tsai_pkg.sv =====
// Package for the 2xSaI pixel scaler: constants, configuration and result types, and
// the colour averaging and vote helpers used by the front end.
// No dependencies.
`timescale 1ns / 1ps
package tsai_pkg;

  localparam int MAX_ROW_LENGTH = 1024;
  localparam int ADDR_W         = $clog2(MAX_ROW_LENGTH);
  localparam int LEN_W          = 11;
  localparam int CNT_W          = 12;
  localparam int PIX_W          = 32;
  localparam int QDEPTH         = 8;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = QPTR_W + 1;

  localparam logic [31:0] HALF_MASK_RST    = 32'h0000_F7DE;
  localparam logic [31:0] HALF_LOW_RST     = 32'h0000_0821;
  localparam logic [31:0] QUARTER_MASK_RST = 32'h0000_E79C;
  localparam logic [31:0] QUARTER_LOW_RST  = 32'h0000_1863;
  localparam logic [LEN_W-1:0] ROW_LENGTH_RST = LEN_W'(259);
  localparam logic [CNT_W-1:0] ROW_COUNT_RST  = CNT_W'(195);

  typedef enum logic [2:0] {
    CFG_HALF_MASK    = 3'd0,
    CFG_HALF_LOW     = 3'd1,
    CFG_QUARTER_MASK = 3'd2,
    CFG_QUARTER_LOW  = 3'd3,
    CFG_ROW_LENGTH   = 3'd4,
    CFG_ROW_COUNT    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0]      half_mask;
    logic [31:0]      half_low;
    logic [31:0]      quarter_mask;
    logic [31:0]      quarter_low;
    logic [LEN_W-1:0] row_length;
    logic [CNT_W-1:0] row_count;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] top_left;
    logic [PIX_W-1:0] top_right;
    logic [PIX_W-1:0] bottom_left;
    logic [PIX_W-1:0] bottom_right;
    logic             row_end;
    logic             frame_end;
  } res_t;

  function automatic logic [31:0] avg2(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] hm, input logic [31:0] hl);
    logic [31:0] s;
    s = ((a & hm) >> 1) + ((b & hm) >> 1) + (a & b & hl);
    return (a == b) ? a : s;
  endfunction

  function automatic logic [31:0] avg4(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] c, input logic [31:0] d,
                                       input logic [31:0] qm, input logic [31:0] ql);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = ((a & qm) >> 2) + ((b & qm) >> 2) + ((c & qm) >> 2) + ((d & qm) >> 2);
    lo = (a & ql) + (b & ql) + (c & ql) + (d & ql);
    return hi + ((lo >> 2) & ql);
  endfunction

  // Arguments are the equality tests a==c, a==d, b==c, b==d of the neighbourhood vote.
  function automatic logic signed [3:0] vote(input logic ac, input logic ad,
                                             input logic bc, input logic bd);
    logic signed [3:0] v;
    if (ac && ad) begin
      v = -4'sd1;
    end else if (bc && !ac && bd && !ad) begin
      v = 4'sd1;
    end else begin
      v = 4'sd0;
    end
    return v;
  endfunction

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

endpackage

// ===== sv/twoxsai_pixel_scaler_top.sv =====
// 2xSaI pixel scaler top level. A result item is formed from the pixel that completes its
// window by line store read, window shift, compare and select, then enters the queue.
// Throughput: one pixel per cycle; the 8-entry result queue sets when input stalls.
// Synchronous active-low reset clears counters, window, pipeline and queue and loads
// the 565 masks and default frame size; line stores are not cleared.
`timescale 1ns / 1ps
module twoxsai_pixel_scaler_top
  import tsai_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic             in_frame_start,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_top_left,
  output logic [PIX_W-1:0] out_top_right,
  output logic [PIX_W-1:0] out_bottom_left,
  output logic [PIX_W-1:0] out_bottom_right,
  output logic             out_row_end,
  output logic             out_frame_end,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);

  cfg_t              cfg_r;
  logic              push;
  res_t              push_data, out_data;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_mask    <= HALF_MASK_RST;
      cfg_r.half_low     <= HALF_LOW_RST;
      cfg_r.quarter_mask <= QUARTER_MASK_RST;
      cfg_r.quarter_low  <= QUARTER_LOW_RST;
      cfg_r.row_length   <= ROW_LENGTH_RST;
      cfg_r.row_count    <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HALF_MASK:    cfg_r.half_mask    <= cfg_wdata;
        CFG_HALF_LOW:     cfg_r.half_low     <= cfg_wdata;
        CFG_QUARTER_MASK: cfg_r.quarter_mask <= cfg_wdata;
        CFG_QUARTER_LOW:  cfg_r.quarter_low  <= cfg_wdata;
        CFG_ROW_LENGTH:   cfg_r.row_length   <= cfg_wdata[LEN_W-1:0];
        CFG_ROW_COUNT:    cfg_r.row_count    <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  tsai_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .q_count        (q_count),
    .push           (push),
    .push_data      (push_data)
  );

  tsai_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (q_count)
  );

  assign out_top_left     = out_data.top_left;
  assign out_top_right    = out_data.top_right;
  assign out_bottom_left  = out_data.bottom_left;
  assign out_bottom_right = out_data.bottom_right;
  assign out_row_end      = out_data.row_end;
  assign out_frame_end    = out_data.frame_end;

endmodule

// ===== sv/tsai_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-before-write on a shared address. No dependencies.
`timescale 1ns / 1ps
module tsai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== sv/tsai_front.sv =====
// Front end of the 2xSaI scaler: position counters, three line stores, the 4x4 window
// and the classification and selection pipeline that pushes results into the queue.
// Depends on tsai_pkg and tsai_ram.
`timescale 1ns / 1ps
module tsai_front
  import tsai_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              in_frame_start,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output res_t              push_data
);

  typedef struct packed {
    logic ad, bc, ae, bl, ac, af, be, bj, ag, co, ab, ah, gc, cm, bf, bd;
    logic ai, ch, cg, cd, bg, bk, ak, bh, bn, an, al, ao, bo;
  } eq_t;

  logic             acc;
  logic [LEN_W-1:0] len_eff;
  logic [CNT_W-1:0] cnt_eff;

  logic [LEN_W-1:0] col_r, col_nxt, c0;
  logic [CNT_W-1:0] row_r, row_nxt, r0;
  logic [1:0]       slot_r, slot_nxt, m0;
  logic             hit, re, fe;

  logic [PIX_W-1:0] rd [3];

  logic             p1_v_r, p1_hit_r, p1_re_r, p1_fe_r;
  logic [PIX_W-1:0] p1_px_r;
  logic [1:0]       p1_slot_r;
  logic [PIX_W-1:0] win_r [16];

  logic             p2_v_r, p2_re_r, p2_fe_r;
  logic             p3_v_r, p3_re_r, p3_fe_r;
  eq_t              eq_nxt, p3_eq_r;
  logic [PIX_W-1:0] p3_a_r, p3_b_r, p3_c_r, p3_ab_r, p3_ac_r, p3_q_r;

  logic [PIX_W-1:0] hp, vp, dp;
  logic signed [3:0] score;
  logic [QCNT_W+1:0] busy;

  assign busy     = (QCNT_W+2)'(q_count) + (QCNT_W+2)'(p1_v_r) + (QCNT_W+2)'(p2_v_r)
                  + (QCNT_W+2)'(p3_v_r);
  assign in_ready = busy < (QCNT_W+2)'(QDEPTH);
  assign acc      = in_valid && in_ready;

  always_comb begin
    if (cfg.row_length < LEN_W'(4)) begin
      len_eff = LEN_W'(4);
    end else if (cfg.row_length > LEN_W'(MAX_ROW_LENGTH)) begin
      len_eff = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len_eff = cfg.row_length;
    end
    cnt_eff = (cfg.row_count < CNT_W'(4)) ? CNT_W'(4) : cfg.row_count;
  end

  // Position of this pixel, then the position the next pixel will take.
  always_comb begin
    c0 = col_r;
    r0 = row_r;
    m0 = slot_r;
    if (in_frame_start) begin
      c0 = '0;
      r0 = '0;
      m0 = '0;
    end
    if (c0 >= len_eff) begin
      c0 = '0;
      r0 = r0 + CNT_W'(1);
      m0 = slot_inc(m0);
    end
    if (r0 >= cnt_eff) begin
      r0 = '0;
      m0 = '0;
    end
    hit = (r0 >= CNT_W'(3)) && (c0 >= LEN_W'(3));
    re  = (c0 == len_eff - LEN_W'(1));
    fe  = re && (r0 == cnt_eff - CNT_W'(1));

    col_nxt  = c0 + LEN_W'(1);
    row_nxt  = r0;
    slot_nxt = m0;
    if (col_nxt >= len_eff) begin
      col_nxt  = '0;
      row_nxt  = r0 + CNT_W'(1);
      slot_nxt = slot_inc(m0);
      if (row_nxt >= cnt_eff) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_line
    tsai_ram #(.WIDTH(PIX_W), .DEPTH(MAX_ROW_LENGTH)) u_line (
      .clk   (clk),
      .we    (acc && (m0 == 2'(j))),
      .waddr (c0[ADDR_W-1:0]),
      .wdata (in_pixel),
      .raddr (c0[ADDR_W-1:0]),
      .rdata (rd[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        slot_r <= slot_nxt;
      end
      p1_v_r <= acc;
      if (p1_v_r) begin
        for (int k = 0; k < 4; k++) begin
          win_r[k*4+0] <= win_r[k*4+1];
          win_r[k*4+1] <= win_r[k*4+2];
          win_r[k*4+2] <= win_r[k*4+3];
        end
        win_r[3]  <= rd[p1_slot_r];
        win_r[7]  <= rd[slot_inc(p1_slot_r)];
        win_r[11] <= rd[slot_inc(slot_inc(p1_slot_r))];
        win_r[15] <= p1_px_r;
      end
      p2_v_r <= p1_v_r && p1_hit_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_hit_r  <= hit;
    p1_re_r   <= re;
    p1_fe_r   <= fe;
    p1_px_r   <= in_pixel;
    p1_slot_r <= m0;
    p2_re_r   <= p1_re_r;
    p2_fe_r   <= p1_fe_r;
    p3_re_r   <= p2_re_r;
    p3_fe_r   <= p2_fe_r;
    p3_eq_r   <= eq_nxt;
    p3_a_r    <= win_r[5];
    p3_b_r    <= win_r[6];
    p3_c_r    <= win_r[9];
    p3_ab_r   <= avg2(win_r[5], win_r[6], cfg.half_mask, cfg.half_low);
    p3_ac_r   <= avg2(win_r[5], win_r[9], cfg.half_mask, cfg.half_low);
    p3_q_r    <= avg4(win_r[5], win_r[6], win_r[9], win_r[10],
                      cfg.quarter_mask, cfg.quarter_low);
  end

  // Window layout: I E F J / G A B K / H C D L / M N O.
  always_comb begin
    eq_nxt.ad = win_r[5] == win_r[10];
    eq_nxt.bc = win_r[6] == win_r[9];
    eq_nxt.ae = win_r[5] == win_r[1];
    eq_nxt.bl = win_r[6] == win_r[11];
    eq_nxt.ac = win_r[5] == win_r[9];
    eq_nxt.af = win_r[5] == win_r[2];
    eq_nxt.be = win_r[6] == win_r[1];
    eq_nxt.bj = win_r[6] == win_r[3];
    eq_nxt.ag = win_r[5] == win_r[4];
    eq_nxt.co = win_r[9] == win_r[14];
    eq_nxt.ab = win_r[5] == win_r[6];
    eq_nxt.ah = win_r[5] == win_r[8];
    eq_nxt.gc = win_r[4] == win_r[9];
    eq_nxt.cm = win_r[9] == win_r[12];
    eq_nxt.bf = win_r[6] == win_r[2];
    eq_nxt.bd = win_r[6] == win_r[10];
    eq_nxt.ai = win_r[5] == win_r[0];
    eq_nxt.ch = win_r[9] == win_r[8];
    eq_nxt.cg = win_r[9] == win_r[4];
    eq_nxt.cd = win_r[9] == win_r[10];
    eq_nxt.bg = win_r[6] == win_r[4];
    eq_nxt.bk = win_r[6] == win_r[7];
    eq_nxt.ak = win_r[5] == win_r[7];
    eq_nxt.bh = win_r[6] == win_r[8];
    eq_nxt.bn = win_r[6] == win_r[13];
    eq_nxt.an = win_r[5] == win_r[13];
    eq_nxt.al = win_r[5] == win_r[11];
    eq_nxt.ao = win_r[5] == win_r[14];
    eq_nxt.bo = win_r[6] == win_r[14];
  end

  always_comb begin
    eq_t e;
    e     = p3_eq_r;
    score = vote(e.ag, e.ae, e.bg, e.be) - vote(e.bk, e.bf, e.ak, e.af)
          - vote(e.bh, e.bn, e.ah, e.an) + vote(e.al, e.ao, e.bl, e.bo);
    if (e.ad && !e.bc) begin
      hp = ((e.ae && e.bl) || (e.ac && e.af && !e.be && e.bj)) ? p3_a_r : p3_ab_r;
      vp = ((e.ag && e.co) || (e.ab && e.ah && !e.gc && e.cm)) ? p3_a_r : p3_ac_r;
      dp = p3_a_r;
    end else if (e.bc && !e.ad) begin
      hp = ((e.bf && e.ah) || (e.be && e.bd && !e.af && e.ai)) ? p3_b_r : p3_ab_r;
      vp = ((e.ch && e.af) || (e.cg && e.cd && !e.ah && e.ai)) ? p3_c_r : p3_ac_r;
      dp = p3_b_r;
    end else if (e.ad && e.bc) begin
      if (e.ab) begin
        hp = p3_a_r;
        vp = p3_a_r;
        dp = p3_a_r;
      end else begin
        hp = p3_ab_r;
        vp = p3_ac_r;
        if (score > 4'sd0) begin
          dp = p3_a_r;
        end else if (score < 4'sd0) begin
          dp = p3_b_r;
        end else begin
          dp = p3_q_r;
        end
      end
    end else begin
      dp = p3_q_r;
      if (e.ac && e.af && !e.be && e.bj) begin
        hp = p3_a_r;
      end else if (e.be && e.bd && !e.af && e.ai) begin
        hp = p3_b_r;
      end else begin
        hp = p3_ab_r;
      end
      if (e.ab && e.ah && !e.gc && e.cm) begin
        vp = p3_a_r;
      end else if (e.cg && e.cd && !e.ah && e.ai) begin
        vp = p3_c_r;
      end else begin
        vp = p3_ac_r;
      end
    end
  end

  assign push                   = p3_v_r;
  assign push_data.top_left     = p3_a_r;
  assign push_data.top_right    = hp;
  assign push_data.bottom_left  = vp;
  assign push_data.bottom_right = dp;
  assign push_data.row_end      = p3_re_r;
  assign push_data.frame_end    = p3_fe_r;

endmodule

// ===== sv/tsai_queue.sv =====
// Result queue of the 2xSaI scaler: holds finished results until the consumer takes them.
// Depends on tsai_pkg.
`timescale 1ns / 1ps
module tsai_queue
  import tsai_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  res_t              push_data,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              out_data,
  output logic [QCNT_W-1:0] count
);

  res_t              buf_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] count_r;
  logic              pop;

  assign out_valid = count_r != '0;
  assign pop       = out_valid && out_ready;
  assign out_data  = buf_r[rp_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== sv/tsai_checker.sv =====
// Port-level checks for the 2xSaI scaler top level, attached by a bind statement.
// Depends on tsai_pkg.
`timescale 1ns / 1ps
module tsai_checker
  import tsai_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_top_left,
  input logic [PIX_W-1:0] out_bottom_right,
  input logic             out_row_end,
  input logic             out_frame_end
);

  // The last item of a frame is always also the last of its row.
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame_end without row_end");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_top_left)
      && $stable(out_bottom_right))
    else $error("stalled item changed");

endmodule

bind twoxsai_pixel_scaler_top tsai_checker u_tsai_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_top_left     (out_top_left),
  .out_bottom_right (out_bottom_right),
  .out_row_end      (out_row_end),
  .out_frame_end    (out_frame_end)
);

// ===== tb/sv/twoxsai_pixel_scaler_top_test.sv =====
// Testbench for the 2xSaI pixel scaler: streams frames under several mask and size
// settings and checks every result item against a local model of the doubler.
// Depends on tsai_pkg and twoxsai_pixel_scaler_top.
`timescale 1ns / 1ps
module twoxsai_pixel_scaler_top_test;
  import tsai_pkg::*;

  typedef struct packed {
    logic [31:0] px;
    logic        fs;
    logic        typed;
    res_t        want;
  } stim_row_t;

  typedef struct {
    logic [31:0] hm, hl, qm, ql, len_w, cnt_w;
    int          len, rows, frames;
  } setting_t;

  localparam res_t ALL_ONES = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 1'b1, 1'b1};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] in_pixel = '0;
  logic             in_frame_start = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] out_top_left, out_top_right, out_bottom_left, out_bottom_right;
  logic             out_row_end, out_frame_end;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [31:0]      cfg_wdata = '0;

  // Local copy of the scaler's configuration and state.
  logic [31:0] m_half, m_half_low, m_quarter, m_quarter_low;
  logic [10:0] m_row_length;
  logic [11:0] m_row_count;
  logic [31:0] line_mem [0:3*MAX_ROW_LENGTH-1];
  logic [31:0] win [0:15];
  int          col_pos, row_pos;

  res_t        expected_q [$];
  int          failures = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_stall = 0;
  logic [31:0] palette [0:3];

  always #1 clk = ~clk;

  twoxsai_pixel_scaler_top u_top (.*);

  function automatic logic [31:0] blend2(logic [31:0] a, logic [31:0] b);
    if (a == b) return a;
    return ((a & m_half) >> 1) + ((b & m_half) >> 1) + (a & b & m_half_low);
  endfunction

  function automatic logic [31:0] blend4(logic [31:0] a, logic [31:0] b,
                                         logic [31:0] c, logic [31:0] d);
    logic [31:0] hi, lo;
    hi = ((a & m_quarter) >> 2) + ((b & m_quarter) >> 2) +
         ((c & m_quarter) >> 2) + ((d & m_quarter) >> 2);
    lo = (a & m_quarter_low) + (b & m_quarter_low) + (c & m_quarter_low) +
         (d & m_quarter_low);
    return hi + ((lo >> 2) & m_quarter_low);
  endfunction

  function automatic int tally(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    int xa, yb;
    xa = int'(a == c) + int'(a == d);
    yb = int'((b == c) && (a != c)) + int'((b == d) && (a != d));
    if (xa == 2) return -1;
    if (yb == 2) return 1;
    return 0;
  endfunction

  // Advances the local state by one pixel; returns 1 when a doubled block is due.
  function automatic bit double_pixel(logic [31:0] px, logic fs, output res_t r);
    int len, cnt, s0, s1, s2, vt;
    logic [31:0] I, E, F, J, G, A, B, K, H, C, D, L, M, N, O, hp, vp, dp;
    bit got;
    len = (m_row_length < 4) ? 4 : (m_row_length > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH
                                                                    : int'(m_row_length);
    cnt = (m_row_count < 4) ? 4 : int'(m_row_count);
    got = 1'b0;
    r = '0;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= len) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= cnt) row_pos = 0;
    s0 = (row_pos % 3) * MAX_ROW_LENGTH + col_pos;
    s1 = ((row_pos + 1) % 3) * MAX_ROW_LENGTH + col_pos;
    s2 = ((row_pos + 2) % 3) * MAX_ROW_LENGTH + col_pos;
    for (int k = 0; k < 4; k++) begin
      win[k*4] = win[k*4+1];
      win[k*4+1] = win[k*4+2];
      win[k*4+2] = win[k*4+3];
    end
    win[3] = line_mem[s0];
    win[7] = line_mem[s1];
    win[11] = line_mem[s2];
    win[15] = px;
    line_mem[s0] = px;
    if (row_pos >= 3 && col_pos >= 3) begin
      I = win[0]; E = win[1]; F = win[2]; J = win[3];
      G = win[4]; A = win[5]; B = win[6]; K = win[7];
      H = win[8]; C = win[9]; D = win[10]; L = win[11];
      M = win[12]; N = win[13]; O = win[14];
      if (A == D && B != C) begin
        hp = ((A == E && B == L) || (A == C && A == F && B != E && B == J)) ? A
                                                                           : blend2(A, B);
        vp = ((A == G && C == O) || (A == B && A == H && G != C && C == M)) ? A
                                                                           : blend2(A, C);
        dp = A;
      end else if (B == C && A != D) begin
        hp = ((B == F && A == H) || (B == E && B == D && A != F && A == I)) ? B
                                                                           : blend2(A, B);
        vp = ((C == H && A == F) || (C == G && C == D && A != H && A == I)) ? C
                                                                           : blend2(A, C);
        dp = B;
      end else if (A == D && B == C) begin
        if (A == B) begin
          hp = A; vp = A; dp = A;
        end else begin
          hp = blend2(A, B);
          vp = blend2(A, C);
          vt = tally(A, B, G, E) - tally(B, A, K, F) - tally(B, A, H, N) + tally(A, B, L, O);
          dp = (vt > 0) ? A : (vt < 0) ? B : blend4(A, B, C, D);
        end
      end else begin
        dp = blend4(A, B, C, D);
        if (A == C && A == F && B != E && B == J) hp = A;
        else if (B == E && B == D && A != F && A == I) hp = B;
        else hp = blend2(A, B);
        if (A == B && A == H && G != C && C == M) vp = A;
        else if (C == G && C == D && A != H && A == I) vp = C;
        else vp = blend2(A, C);
      end
      r.top_left = A;
      r.top_right = hp;
      r.bottom_left = vp;
      r.bottom_right = dp;
      r.row_end = (col_pos == len - 1);
      r.frame_end = r.row_end && (row_pos == cnt - 1);
      got = 1'b1;
    end
    col_pos++;
    if (col_pos >= len) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= cnt) row_pos = 0;
    end
    return got;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_pixel(logic [31:0] px, logic fs, bit typed = 1'b0, res_t want = '0);
    res_t r;
    bit   rdy;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    in_frame_start <= fs;
    if (double_pixel(px, fs, r)) expected_q.push_back(typed ? want : r);
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // Items that make no result may still be in the pipeline.
    repeat (8) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after its last write.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_HALF_MASK:    m_half = val;
      CFG_HALF_LOW:     m_half_low = val;
      CFG_QUARTER_MASK: m_quarter = val;
      CFG_QUARTER_LOW:  m_quarter_low = val;
      CFG_ROW_LENGTH:   m_row_length = val[10:0];
      CFG_ROW_COUNT:    m_row_count = val[11:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_pixel();
    return ($urandom_range(0, 99) < 85) ? palette[$urandom_range(0, 3)] : $urandom;
  endfunction

  task automatic run_setting(setting_t s);
    drain();
    write_reg(CFG_HALF_MASK, s.hm);
    write_reg(CFG_HALF_LOW, s.hl);
    write_reg(CFG_QUARTER_MASK, s.qm);
    write_reg(CFG_QUARTER_LOW, s.ql);
    write_reg(CFG_ROW_LENGTH, s.len_w);
    write_reg(CFG_ROW_COUNT, s.cnt_w);
    cfg_we <= 1'b0;
    for (int f = 0; f < s.frames; f++) begin
      palette[0] = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
      palette[1] = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
      palette[2] = $urandom;
      palette[3] = $urandom;
      for (int y = 0; y < s.rows; y++) begin
        for (int x = 0; x < s.len; x++) begin
          // The first frame of a setting always restarts the counters; later ones
          // sometimes rely on the wrap, and now and then a frame is cut short.
          if (x == 0 && y == 0)
            send_pixel(pick_pixel(), (f == 0) || ($urandom_range(0, 3) != 0));
          else
            send_pixel(pick_pixel(), $urandom_range(0, 299) == 0);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      rx_stall <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Outputs are stable at the falling edge, ahead of the edge that takes the item.
  always @(negedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected");
        failures++;
      end else begin
        want = expected_q.pop_front();
        if (out_top_left !== want.top_left) begin
          $error("top_left: expected %h, got %h", want.top_left, out_top_left);
          failures++;
        end
        if (out_top_right !== want.top_right) begin
          $error("top_right: expected %h, got %h", want.top_right, out_top_right);
          failures++;
        end
        if (out_bottom_left !== want.bottom_left) begin
          $error("bottom_left: expected %h, got %h", want.bottom_left, out_bottom_left);
          failures++;
        end
        if (out_bottom_right !== want.bottom_right) begin
          $error("bottom_right: expected %h, got %h", want.bottom_right, out_bottom_right);
          failures++;
        end
        if (out_row_end !== want.row_end) begin
          $error("row_end: expected %b, got %b", want.row_end, out_row_end);
          failures++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, out_frame_end);
          failures++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[twoxsai_pixel_scaler_top] ERROR");
    $finish;
  end

  initial begin
    stim_row_t directed [16];
    setting_t  plan [8];
    m_half = HALF_MASK_RST;
    m_half_low = HALF_LOW_RST;
    m_quarter = QUARTER_MASK_RST;
    m_quarter_low = QUARTER_LOW_RST;
    m_row_length = ROW_LENGTH_RST;
    m_row_count = ROW_COUNT_RST;
    for (int i = 0; i < 3 * MAX_ROW_LENGTH; i++) line_mem[i] = '0;
    for (int i = 0; i < 16; i++) win[i] = '0;
    col_pos = 0;
    row_pos = 0;

    // A 4x4 frame of white: its single block is white, closing both row and frame.
    for (int i = 0; i < 16; i++) directed[i] = '{32'hFFFF_FFFF, i == 0, i == 15, ALL_ONES};

    plan[0] = '{32'h0000_F7DE, 32'h0000_0821, 32'h0000_E79C, 32'h0000_1863, 6, 5, 6, 5, 8};
    plan[1] = '{32'h0000_7BDE, 32'h0000_0421, 32'h0000_739C, 32'h0000_0C63, 0, 0, 4, 4, 8};
    plan[2] = '{32'h00FE_FEFE, 32'h0001_0101, 32'h00FC_FCFC, 32'h0003_0303, 9, 6, 9, 6, 4};
    plan[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_F805, 4, 5, 4, 6};
    plan[4] = '{32'h0, 32'h0, 32'h0, 32'h0, 7, 5, 7, 5, 4};
    plan[5] = '{$urandom, $urandom, $urandom, $urandom, 3, 1, 4, 4, 6};
    plan[6] = '{32'h0000_F7DE, 32'h0000_0821, 32'h0000_E79C, 32'h0000_1863,
                5, 4095, 5, 8, 2};
    plan[7] = '{32'h00FE_FEFE, 32'h0001_0101, 32'h00FC_FCFC, 32'h0003_0303, 8, 6, 8, 6, 5};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(CFG_ROW_LENGTH, 32'd4);
    write_reg(CFG_ROW_COUNT, 32'd4);
    cfg_we <= 1'b0;
    foreach (directed[i]) send_pixel(directed[i].px, directed[i].fs, directed[i].typed,
                                     directed[i].want);

    for (int p = 0; p < 8; p++) begin
      if (p == 7) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      run_setting(plan[p]);
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("[twoxsai_pixel_scaler_top] OK");
    end else begin
      $display("[twoxsai_pixel_scaler_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tsai_pkg.sv
sv/tsai_ram.sv
sv/tsai_front.sv
sv/tsai_queue.sv
sv/twoxsai_pixel_scaler_top.sv
sv/tsai_checker.sv
tb/sv/twoxsai_pixel_scaler_top_test.sv
